>>> rtl/sensor_request_framer_crc16_assert.svh
// ---------------------------------------------------------------------------
// sensor request framer assertion macros
// shared concurrent assertion forms for the framer rtl
// ---------------------------------------------------------------------------
`ifndef SENSOR_REQUEST_FRAMER_CRC16_ASSERT_SVH
`define SENSOR_REQUEST_FRAMER_CRC16_ASSERT_SVH

// same-cycle implication, masked during reset
`define SRF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer assertion failed");

// next-cycle implication, masked during reset
`define SRF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer assertion failed");

`endif

>>> rtl/srf_pkg.sv
// ---------------------------------------------------------------------------
// srf_pkg
// types, constants and the crc helper shared by the framer modules
// ---------------------------------------------------------------------------
package srf_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd1;

   // one queued request, already stamped with the device address
   typedef struct packed {
      logic [7:0] device_address;
      logic [7:0] function_code;
      logic [7:0] parameter_req;
      logic       has_parameter;
   } entry_type;

   // queue fill status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // back end status for the top level
   typedef struct packed {
      logic idle;
      logic load;
   } back_status_type;

   // one byte through the reflected crc-16/modbus
   function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc,
                                                  input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/srf_front.sv
// ---------------------------------------------------------------------------
// srf_front
// holds the device address register and turns each accepted request into
// a queue entry
// ---------------------------------------------------------------------------
module srf_front
   import srf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [7:0]   req_function_code,
   input  logic [7:0]   req_parameter_req,
   input  logic         req_has_parameter,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_device_address,
   input  q_status_type q_status,
   output logic         push,
   output entry_type    push_entry
);

   logic [7:0] addr_ff;
   logic [7:0] addr_in;

   // device address register
   always_comb begin
      addr_in = addr_ff;
      if (csr_valid && csr_ready) begin
         addr_in = csr_device_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= DEVICE_ADDRESS_RESET;
      end else begin
         addr_ff <= addr_in;
      end
   end

   assign csr_ready = 1'b1;

   // accept while the queue has room
   assign busy = q_status.full;
   assign push = start && !busy;

   // build the entry, parameter byte dropped when absent
   always_comb begin
      push_entry.device_address = addr_ff;
      push_entry.function_code  = req_function_code;
      push_entry.parameter_req  = req_has_parameter ? req_parameter_req : 8'h00;
      push_entry.has_parameter  = req_has_parameter;
   end

endmodule

>>> rtl/srf_queue.sv
// ---------------------------------------------------------------------------
// srf_queue
// small request queue between front and back
// ---------------------------------------------------------------------------
module srf_queue
   import srf_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    head_entry,
   output q_status_type q_status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_FULL);

endmodule

>>> rtl/srf_back.sv
// ---------------------------------------------------------------------------
// srf_back
// sends one request frame a byte per cycle and folds each data byte into
// the running crc
// ---------------------------------------------------------------------------
module srf_back
   import srf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  q_status_type    q_status,
   input  entry_type       head_entry,
   output logic            pop,
   output back_status_type back_status,
   output logic            rsp_strobe,
   output logic [7:0]      rsp_frame_byte,
   output logic            rsp_last_byte
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ADDR   = 6'b000010,
      ST_FUNC   = 6'b000100,
      ST_PARAM  = 6'b001000,
      ST_CRC_HI = 6'b010000,
      ST_CRC_LO = 6'b100000
   } state_type;

   state_type   state_ff;
   state_type   state_in;
   entry_type   cur_ff;
   entry_type   cur_in;
   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [7:0]  byte_sel;
   logic        strobe_ff;
   logic        strobe_in;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic        last_in;

   // load a new request when idle or on the closing byte
   assign pop = !q_status.empty && (state_ff == ST_IDLE || state_ff == ST_CRC_LO);

   // byte for the current step
   always_comb begin
      case (state_ff)
         ST_ADDR:   byte_sel = cur_ff.device_address;
         ST_FUNC:   byte_sel = cur_ff.function_code;
         ST_PARAM:  byte_sel = cur_ff.parameter_req;
         ST_CRC_HI: byte_sel = crc_ff[15:8];
         ST_CRC_LO: byte_sel = crc_ff[7:0];
         default:   byte_sel = 8'h00;
      endcase
   end

   // sequencer and crc
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      crc_in   = crc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_FUNC;
            crc_in   = crc16_add_byte(crc_ff, byte_sel);
         end
         ST_FUNC: begin
            state_in = cur_ff.has_parameter ? ST_PARAM : ST_CRC_HI;
            crc_in   = crc16_add_byte(crc_ff, byte_sel);
         end
         ST_PARAM: begin
            state_in = ST_CRC_HI;
            crc_in   = crc16_add_byte(crc_ff, byte_sel);
         end
         ST_CRC_HI: begin
            state_in = ST_CRC_LO;
         end
         ST_CRC_LO: begin
            state_in = pop ? ST_ADDR : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (pop) begin
         cur_in = head_entry;
         crc_in = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      crc_ff <= crc_in;
   end

   // output register
   assign strobe_in = (state_ff != ST_IDLE);
   assign last_in   = (state_ff == ST_CRC_LO);

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_sel;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte  = last_ff;

   assign back_status.idle = (state_ff == ST_IDLE);
   assign back_status.load = pop;

endmodule

>>> rtl/sensor_request_framer_crc16.sv
// ---------------------------------------------------------------------------
// sensor_request_framer_crc16
// frames sensor requests as address, function, optional parameter and a
// crc-16/modbus checksum, sent one byte per cycle
// ---------------------------------------------------------------------------
// usage
//   request: drive req_* and raise start; it is taken on a rising edge with
//   start high and busy low. busy is high only while the request queue is
//   full.
//   response: each frame byte appears on rsp_frame_byte for one cycle with
//   rsp_strobe high; rsp_last_byte marks the crc low byte. Bytes go out in
//   order address, function, parameter (when present), crc high, crc low.
//   The receiver has no back pressure; bytes flow without gaps.
//   when the back end is idle, an accepted request goes through the queue, is
//   loaded into the back end, and its first byte leaves via the output register.
//   throughput: one frame byte per cycle; a frame is 4 bytes without a
//   parameter and 5 with one; the byte sequencer in the back end sets this.
//   Back-to-back frames follow each other with no idle cycle.
//   csr: one write channel for the device address, always ready; write it
//   only while no frame is pending. Reset sets the address to 1, empties the
//   queue and idles the sequencer.
// ---------------------------------------------------------------------------
`include "sensor_request_framer_crc16_assert.svh"

module sensor_request_framer_crc16
   import srf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_function_code,
   input  logic [7:0] req_parameter_req,
   input  logic       req_has_parameter,
   output logic       rsp_strobe,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_last_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_device_address
);

   q_status_type    q_status;
   back_status_type back_status;
   entry_type       push_entry;
   entry_type       head_entry;
   logic            push;
   logic            pop;
   logic            idle_take;

   // request intake and address register
   srf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_function_code  (req_function_code),
      .req_parameter_req  (req_parameter_req),
      .req_has_parameter  (req_has_parameter),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_device_address (csr_device_address),
      .q_status           (q_status),
      .push               (push),
      .push_entry         (push_entry)
   );

   // request queue
   srf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // frame sequencer
   srf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head_entry     (head_entry),
      .pop            (pop),
      .back_status    (back_status),
      .rsp_strobe     (rsp_strobe),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   // request taken while everything is empty
   assign idle_take = start && !busy && q_status.empty && back_status.idle;

   // checks
   `SRF_ASSERT_NXT(a_idle_request_loads, clock, reset, idle_take, back_status.load)
   `SRF_ASSERT_NXT(a_load_starts_frame, clock, reset, back_status.load, !back_status.idle)
   `SRF_ASSERT_NXT(a_frame_no_gap, clock, reset, rsp_strobe && !rsp_last_byte, rsp_strobe)
   `SRF_ASSERT_IMP(a_last_after_byte, clock, reset, rsp_last_byte, rsp_strobe && $past(rsp_strobe))

endmodule
